// ===== rtl/lav_pkg.sv =====
// Package for the look-at view matrix block.
// Holds the fixed-point types, field widths and row codes shared by all files.
// No dependencies.
package lav_pkg;

    // Signed 32-bit fixed-point word (Q16.16 positions, Q2.30 unit vectors).
    typedef logic signed [31:0] t_q;

    // Three-component vector packed for sideband transport.
    typedef struct packed {
        t_q x;
        t_q y;
        t_q z;
    } t_xyz;

    // Matrix row code.
    localparam int ROW_W = 2;
    typedef logic [ROW_W-1:0] t_row;
    localparam t_row ROW_FIRST = 2'd0;
    localparam t_row ROW_LAST  = 2'd2;

    // Element widths of the three vectors that get normalized.
    localparam int D_W  = 33;   // camera minus target
    localparam int RR_W = 32;   // forward cross (0,1,0)
    localparam int UR_W = 64;   // right cross forward

    // Normalizer datapath widths.
    localparam int SCL_W = 30;          // scaled magnitude, top bit at 2^29
    localparam int SQ_W  = 2 * SCL_W + 2; // sum of three squares
    localparam int LEN_W = 31;          // integer square root of the sum
    localparam int NUM_W = 2 * SCL_W + 1; // rounded dividend
    localparam int QUO_W = 31;          // quotient, at most 2^30

    // Unit length in Q2.30.
    localparam t_q Q30_ONE = 32'sd1073741824;

endpackage

// ===== rtl/lav_pos_if.sv =====
// Input channel interface: camera and target positions with valid/ready.
// Depends on lav_pkg.
interface lav_pos_if import lav_pkg::*; ();
    logic valid;
    logic ready;
    t_q   cam_x;
    t_q   cam_y;
    t_q   cam_z;
    t_q   target_x;
    t_q   target_y;
    t_q   target_z;

    modport source (output valid, output cam_x, output cam_y, output cam_z,
                    output target_x, output target_y, output target_z, input ready);
    modport sink   (input valid, input cam_x, input cam_y, input cam_z,
                    input target_x, input target_y, input target_z, output ready);
endinterface

// ===== rtl/lav_row_if.sv =====
// Output channel interface: one view matrix row per transfer, valid/ready.
// Depends on lav_pkg.
interface lav_row_if import lav_pkg::*; ();
    logic valid;
    logic ready;
    t_row row_index;
    t_q   right_part;
    t_q   up_part;
    t_q   forward_part;
    t_q   translation_part;
    logic degenerate;
    logic last_row;

    modport source (output valid, output row_index, output right_part, output up_part,
                    output forward_part, output translation_part, output degenerate,
                    output last_row, input ready);
    modport sink   (input valid, input row_index, input right_part, input up_part,
                    input forward_part, input translation_part, input degenerate,
                    input last_row, output ready);
endinterface

// ===== rtl/look_at_view_matrix.sv =====
// Look-at view matrix: three matrix rows per camera/target pair.
// The first row is offered once the item has passed the pipeline into the row buffer,
// the other two as the output accepts them. The pipeline takes new items while earlier
// ones are in flight; it stalls only while a finished item cannot enter the row buffer.
// Reset (synchronous, active low) empties the pipeline and the row buffer.
// Depends on lav_pkg, lav_pos_if, lav_row_if and lav_norm.
module look_at_view_matrix import lav_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lav_pos_if.sink      i_pos,
    lav_row_if.source    o_row
);
    typedef struct packed {
        t_xyz p;
        t_xyz f;
        logic ok;
    } t_s2;

    typedef struct packed {
        t_xyz p;
        t_xyz f;
        t_xyz r;
        logic ok;
    } t_s3;

    logic                   w_en;
    logic                   w_load;
    logic                   w_fin;
    logic                   w_xfer;

    logic signed [D_W-1:0]  w_d [3];
    t_xyz                   w_p_in;
    logic                   w_n1_vld;
    t_q                     w_f [3];
    logic                   w_ok1;
    t_xyz                   w_s1;

    logic signed [RR_W-1:0] w_rr [3];
    t_s2                    w_s2_in;
    logic                   w_n2_vld;
    t_q                     w_r [3];
    logic                   w_ok2;
    t_s2                    w_s2;

    logic                   r3_vld;
    logic signed [63:0]     r3_a;
    logic signed [63:0]     r3_b;
    logic signed [63:0]     r3_c;
    logic signed [63:0]     r3_d;
    t_s3                    r3_s;

    logic                   r4_vld;
    logic signed [UR_W-1:0] r4_ur [3];
    t_s3                    r4_s;

    logic                   w_n3_vld;
    t_q                     w_u [3];
    logic                   w_ok3;
    t_s3                    w_s3;
    t_q                     w_rv [3];
    t_q                     w_fv [3];
    t_q                     w_pv [3];

    logic                   r5_vld;
    logic signed [63:0]     r5_m [3][3];
    t_q                     r5_r [3];
    t_q                     r5_u [3];
    t_q                     r5_f [3];
    logic                   r5_ok;

    logic                   r6_vld;
    logic signed [63:0]     r6_sum [3];
    t_q                     r6_r [3];
    t_q                     r6_u [3];
    t_q                     r6_f [3];
    logic                   r6_ok;

    logic signed [64:0]     w_v [3];
    logic signed [34:0]     w_tq [3];
    t_q                     w_trn [3];

    logic                   r7_vld;
    t_q                     r7_r [3];
    t_q                     r7_u [3];
    t_q                     r7_f [3];
    t_q                     r7_t [3];
    logic                   r7_deg;

    logic                   r_busy;
    t_row                   r_row;
    t_q                     r_sr [3];
    t_q                     r_su [3];
    t_q                     r_sf [3];
    t_q                     r_st [3];
    logic                   r_sdeg;

    // Pipeline advance: stall only while a finished item cannot enter the row buffer.
    assign w_xfer = o_row.valid && o_row.ready;
    assign w_fin  = r_busy && o_row.ready && (r_row == ROW_LAST);
    assign w_load = r7_vld && (!r_busy || w_fin);
    assign w_en   = !r7_vld || w_load;
    assign i_pos.ready = w_en;

    // Forward direction from camera minus target.
    assign w_d[0] = D_W'(i_pos.cam_x) - D_W'(i_pos.target_x);
    assign w_d[1] = D_W'(i_pos.cam_y) - D_W'(i_pos.target_y);
    assign w_d[2] = D_W'(i_pos.cam_z) - D_W'(i_pos.target_z);
    assign w_p_in = {i_pos.cam_x, i_pos.cam_y, i_pos.cam_z};

    lav_norm #(
        .W  (D_W),
        .SW ($bits(t_xyz))
    ) u_norm_f (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_pos.valid),
        .i_vec   (w_d),
        .i_side  (w_p_in),
        .o_vld   (w_n1_vld),
        .o_vec   (w_f),
        .o_ok    (w_ok1),
        .o_side  (w_s1)
    );

    // Right direction from forward cross world up.
    assign w_rr[0] = -w_f[2];
    assign w_rr[1] = '0;
    assign w_rr[2] = w_f[0];
    assign w_s2_in = '{p: w_s1, f: '{x: w_f[0], y: w_f[1], z: w_f[2]}, ok: w_ok1};

    lav_norm #(
        .W  (RR_W),
        .SW ($bits(t_s2))
    ) u_norm_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_n1_vld),
        .i_vec   (w_rr),
        .i_side  (w_s2_in),
        .o_vld   (w_n2_vld),
        .o_vec   (w_r),
        .o_ok    (w_ok2),
        .o_side  (w_s2)
    );

    // Up direction: partial products of right cross forward (right.y is zero).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= w_n2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_a <= $signed(w_r[2]) * $signed(w_s2.f.y);
            r3_b <= $signed(w_r[2]) * $signed(w_s2.f.x);
            r3_c <= $signed(w_r[0]) * $signed(w_s2.f.z);
            r3_d <= $signed(w_r[0]) * $signed(w_s2.f.y);
            r3_s <= '{p: w_s2.p, f: w_s2.f, r: '{x: w_r[0], y: w_r[1], z: w_r[2]},
                      ok: w_s2.ok && w_ok2};
            r4_ur[0] <= -r3_a;
            r4_ur[1] <= r3_b - r3_c;
            r4_ur[2] <= r3_d;
            r4_s     <= r3_s;
        end
    end

    lav_norm #(
        .W  (UR_W),
        .SW ($bits(t_s3))
    ) u_norm_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r4_vld),
        .i_vec   (r4_ur),
        .i_side  (r4_s),
        .o_vld   (w_n3_vld),
        .o_vec   (w_u),
        .o_ok    (w_ok3),
        .o_side  (w_s3)
    );

    assign w_rv[0] = w_s3.r.x;
    assign w_rv[1] = w_s3.r.y;
    assign w_rv[2] = w_s3.r.z;
    assign w_fv[0] = w_s3.f.x;
    assign w_fv[1] = w_s3.f.y;
    assign w_fv[2] = w_s3.f.z;
    assign w_pv[0] = w_s3.p.x;
    assign w_pv[1] = w_s3.p.y;
    assign w_pv[2] = w_s3.p.z;

    // Translation: rounded, saturated negative dot product of each row with the camera.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_v[i]  = -65'(r6_sum[i]) + 65'sd536870912;
            w_tq[i] = 35'(w_v[i] >>> 30);
            if (w_tq[i] > 35'sd2147483647) begin
                w_trn[i] = 32'sh7fffffff;
            end else if (w_tq[i] < -35'sd2147483648) begin
                w_trn[i] = 32'sh80000000;
            end else begin
                w_trn[i] = w_tq[i][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (w_en) begin
            r5_vld <= w_n3_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r5_m[i][0] <= $signed(w_rv[i]) * $signed(w_pv[0]);
                r5_m[i][1] <= $signed(w_u[i])  * $signed(w_pv[1]);
                r5_m[i][2] <= $signed(w_fv[i]) * $signed(w_pv[2]);
                r5_r[i]    <= w_rv[i];
                r5_u[i]    <= w_u[i];
                r5_f[i]    <= w_fv[i];
                r6_sum[i]  <= r5_m[i][0] + r5_m[i][1] + r5_m[i][2];
                r6_r[i]    <= r5_r[i];
                r6_u[i]    <= r5_u[i];
                r6_f[i]    <= r5_f[i];
                r7_r[i]    <= r6_ok ? r6_r[i] : '0;
                r7_u[i]    <= r6_ok ? r6_u[i] : '0;
                r7_f[i]    <= r6_ok ? r6_f[i] : '0;
                r7_t[i]    <= r6_ok ? w_trn[i] : '0;
            end
            r5_ok  <= w_s3.ok && w_ok3;
            r6_ok  <= r5_ok;
            r7_deg <= !r6_ok;
        end
    end

    // Row buffer: holds one finished item and sends its three rows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= ROW_FIRST;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_row  <= ROW_FIRST;
        end else if (w_xfer) begin
            if (r_row == ROW_LAST) begin
                r_busy <= 1'b0;
            end else begin
                r_row <= r_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sr   <= r7_r;
            r_su   <= r7_u;
            r_sf   <= r7_f;
            r_st   <= r7_t;
            r_sdeg <= r7_deg;
        end
    end

    assign o_row.valid            = r_busy;
    assign o_row.row_index        = r_row;
    assign o_row.right_part       = r_sr[r_row];
    assign o_row.up_part          = r_su[r_row];
    assign o_row.forward_part     = r_sf[r_row];
    assign o_row.translation_part = r_st[r_row];
    assign o_row.degenerate       = r_sdeg;
    assign o_row.last_row         = (r_row == ROW_LAST);

endmodule

// ===== rtl/lav_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on lav_pkg.
module lav_isqrt import lav_pkg::*; #(
    parameter int SW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [SQ_W-1:0]  i_rad,
    input  logic [SW-1:0]    i_side,
    output logic             o_vld,
    output logic [LEN_W-1:0] o_root,
    output logic [SW-1:0]    o_side
);
    localparam int STEPS = LEN_W;
    localparam int RW    = LEN_W + 2;

    logic [STEPS-1:0] r_vld;
    logic [SQ_W-1:0]  r_rad  [STEPS];
    logic [RW-1:0]    r_rem  [STEPS];
    logic [LEN_W-1:0] r_root [STEPS];
    logic [SW-1:0]    r_side [STEPS];

    logic [SQ_W-1:0]  p_rad  [STEPS];
    logic [RW-1:0]    p_rem  [STEPS];
    logic [LEN_W-1:0] p_root [STEPS];
    logic [SW-1:0]    p_side [STEPS];
    logic [RW+1:0]    w_cur  [STEPS];
    logic [RW+1:0]    w_try  [STEPS];
    logic [RW-1:0]    n_rem  [STEPS];
    logic [LEN_W-1:0] n_root [STEPS];

    // Each stage brings down the next bit pair and tries to set one root bit.
    always_comb begin
        for (int j = 0; j < STEPS; j++) begin
            if (j == 0) begin
                p_rad[j]  = i_rad;
                p_rem[j]  = '0;
                p_root[j] = '0;
                p_side[j] = i_side;
            end else begin
                p_rad[j]  = r_rad[j-1];
                p_rem[j]  = r_rem[j-1];
                p_root[j] = r_root[j-1];
                p_side[j] = r_side[j-1];
            end
            w_cur[j] = {p_rem[j], p_rad[j][2*(STEPS-1-j) +: 2]};
            w_try[j] = {1'b0, p_root[j], 2'b01};
            if (w_cur[j] >= w_try[j]) begin
                n_rem[j]  = RW'(w_cur[j] - w_try[j]);
                n_root[j] = {p_root[j][LEN_W-2:0], 1'b1};
            end else begin
                n_rem[j]  = w_cur[j][RW-1:0];
                n_root[j] = {p_root[j][LEN_W-2:0], 1'b0};
            end
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STEPS-2:0], i_vld};
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < STEPS; j++) begin
                r_rad[j]  <= p_rad[j];
                r_rem[j]  <= n_rem[j];
                r_root[j] <= n_root[j];
                r_side[j] <= p_side[j];
            end
        end
    end

    assign o_vld  = r_vld[STEPS-1];
    assign o_root = r_root[STEPS-1];
    assign o_side = r_side[STEPS-1];

endmodule

// ===== rtl/lav_div.sv =====
// Pipelined restoring divider, three lanes sharing one divisor.
// One quotient bit per stage. Depends on lav_pkg.
module lav_div import lav_pkg::*; #(
    parameter int SW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [NUM_W-1:0] i_num [3],
    input  logic [LEN_W-1:0] i_den,
    input  logic [SW-1:0]    i_side,
    output logic             o_vld,
    output logic [QUO_W-1:0] o_quo [3],
    output logic [SW-1:0]    o_side
);
    localparam int STEPS = QUO_W;
    localparam int RW    = LEN_W + 1;

    logic [STEPS-1:0] r_vld;
    logic [NUM_W-1:0] r_num  [STEPS][3];
    logic [RW-1:0]    r_rem  [STEPS][3];
    logic [QUO_W-1:0] r_quo  [STEPS][3];
    logic [LEN_W-1:0] r_den  [STEPS];
    logic [SW-1:0]    r_side [STEPS];

    logic [NUM_W-1:0] p_num  [STEPS][3];
    logic [RW-1:0]    p_rem  [STEPS][3];
    logic [QUO_W-1:0] p_quo  [STEPS][3];
    logic [LEN_W-1:0] p_den  [STEPS];
    logic [SW-1:0]    p_side [STEPS];
    logic [RW:0]      w_cur  [STEPS][3];
    logic [RW-1:0]    n_rem  [STEPS][3];
    logic [QUO_W-1:0] n_quo  [STEPS][3];

    // Each stage shifts in one dividend bit and subtracts when it fits.
    always_comb begin
        for (int j = 0; j < STEPS; j++) begin
            if (j == 0) begin
                p_den[j]  = i_den;
                p_side[j] = i_side;
            end else begin
                p_den[j]  = r_den[j-1];
                p_side[j] = r_side[j-1];
            end
            for (int k = 0; k < 3; k++) begin
                if (j == 0) begin
                    p_num[j][k] = i_num[k];
                    p_rem[j][k] = RW'(i_num[k][NUM_W-1:QUO_W]);
                    p_quo[j][k] = '0;
                end else begin
                    p_num[j][k] = r_num[j-1][k];
                    p_rem[j][k] = r_rem[j-1][k];
                    p_quo[j][k] = r_quo[j-1][k];
                end
                w_cur[j][k] = {p_rem[j][k], p_num[j][k][STEPS-1-j]};
                if (w_cur[j][k] >= {2'b00, p_den[j]}) begin
                    n_rem[j][k] = RW'(w_cur[j][k] - {2'b00, p_den[j]});
                    n_quo[j][k] = {p_quo[j][k][QUO_W-2:0], 1'b1};
                end else begin
                    n_rem[j][k] = w_cur[j][k][RW-1:0];
                    n_quo[j][k] = {p_quo[j][k][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STEPS-2:0], i_vld};
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < STEPS; j++) begin
                r_den[j]  <= p_den[j];
                r_side[j] <= p_side[j];
                for (int k = 0; k < 3; k++) begin
                    r_num[j][k] <= p_num[j][k];
                    r_rem[j][k] <= n_rem[j][k];
                    r_quo[j][k] <= n_quo[j][k];
                end
            end
        end
    end

    assign o_vld = r_vld[STEPS-1];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_quo[k] = r_quo[STEPS-1][k];
        end
    end
    assign o_side = r_side[STEPS-1];

endmodule

// ===== rtl/lav_norm.sv =====
// Pipelined vector normalizer: scale, sum of squares, square root, divide.
// Result in Q2.30 with a flag for a zero vector. Depends on lav_pkg,
// lav_isqrt and lav_div.
module lav_norm import lav_pkg::*; #(
    parameter int W  = 33,
    parameter int SW = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic signed [W-1:0] i_vec [3],
    input  logic [SW-1:0]       i_side,
    output logic                o_vld,
    output t_q                  o_vec [3],
    output logic                o_ok,
    output logic [SW-1:0]       o_side
);
    localparam int PW = $clog2(W);
    localparam logic [PW-1:0] MSB_TGT = PW'(SCL_W - 1);
    localparam int RSW = SW + 4 + 3 * SCL_W;
    localparam int DSW = SW + 4;

    // Stage 1: magnitudes and signs.
    logic             r1_vld;
    logic [W-1:0]     r1_mag [3];
    logic [2:0]       r1_neg;
    logic [SW-1:0]    r1_side;
    // Stage 2: largest magnitude.
    logic             r2_vld;
    logic [W-1:0]     r2_mag [3];
    logic [W-1:0]     r2_max;
    logic [2:0]       r2_neg;
    logic [SW-1:0]    r2_side;
    // Stage 3: leading one position.
    logic             r3_vld;
    logic [W-1:0]     r3_mag [3];
    logic [PW-1:0]    r3_pos;
    logic             r3_zero;
    logic [2:0]       r3_neg;
    logic [SW-1:0]    r3_side;
    // Stage 4: scaled magnitudes.
    logic             r4_vld;
    logic [SCL_W-1:0] r4_sm [3];
    logic             r4_zero;
    logic [2:0]       r4_neg;
    logic [SW-1:0]    r4_side;
    // Stage 5: squares.
    logic             r5_vld;
    logic [SCL_W-1:0] r5_sm [3];
    logic [2*SCL_W-1:0] r5_sq [3];
    logic             r5_zero;
    logic [2:0]       r5_neg;
    logic [SW-1:0]    r5_side;
    // Stage 6: sum of squares.
    logic             r6_vld;
    logic [SCL_W-1:0] r6_sm [3];
    logic [SQ_W-1:0]  r6_sum;
    logic             r6_zero;
    logic [2:0]       r6_neg;
    logic [SW-1:0]    r6_side;
    // Stage after the root: dividends and divisor.
    logic             r7_vld;
    logic [NUM_W-1:0] r7_num [3];
    logic [LEN_W-1:0] r7_den;
    logic [DSW-1:0]   r7_dside;
    // Output stage.
    logic             r8_vld;
    t_q               r8_vec [3];
    logic             r8_ok;
    logic [SW-1:0]    r8_side;

    logic [W-1:0]     w_m01;
    logic [W-1:0]     w_max;
    logic [PW-1:0]    w_pos;
    logic [W-1:0]     w_sh [3];
    logic [RSW-1:0]   w_rt_in;
    logic             w_rt_vld;
    logic [LEN_W-1:0] w_len;
    logic [RSW-1:0]   w_rt_out;
    logic [SW-1:0]    w_a_side;
    logic [2:0]       w_a_neg;
    logic             w_a_zero;
    logic [SCL_W-1:0] w_a_sm0;
    logic [SCL_W-1:0] w_a_sm1;
    logic [SCL_W-1:0] w_a_sm2;
    logic             w_dv_vld;
    logic [QUO_W-1:0] w_quo [3];
    logic [DSW-1:0]   w_dv_side;
    logic [SW-1:0]    w_b_side;
    logic [2:0]       w_b_neg;
    logic             w_b_zero;
    logic [31:0]      w_qx [3];

    // Valid bits of the local stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= w_rt_vld;
            r8_vld <= w_dv_vld;
        end
    end

    // Maximum of three magnitudes and position of its leading one.
    always_comb begin
        w_m01 = (r1_mag[0] > r1_mag[1]) ? r1_mag[0] : r1_mag[1];
        w_max = (w_m01 > r1_mag[2]) ? w_m01 : r1_mag[2];
        w_pos = '0;
        for (int b = 0; b < W; b++) begin
            if (r2_max[b]) begin
                w_pos = PW'(b);
            end
        end
    end

    // Shift every magnitude so that the largest has its top bit at 2^29.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r3_pos > MSB_TGT) begin
                w_sh[k] = r3_mag[k] >> (r3_pos - MSB_TGT);
            end else begin
                w_sh[k] = r3_mag[k] << (MSB_TGT - r3_pos);
            end
        end
    end

    // Front stages up to the sum of squares.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_neg[k] <= i_vec[k][W-1];
                r1_mag[k] <= i_vec[k][W-1] ? W'(-i_vec[k]) : W'(i_vec[k]);
                r2_mag[k] <= r1_mag[k];
                r3_mag[k] <= r2_mag[k];
                r4_sm[k]  <= w_sh[k][SCL_W-1:0];
                r5_sm[k]  <= r4_sm[k];
                r5_sq[k]  <= r4_sm[k] * r4_sm[k];
                r6_sm[k]  <= r5_sm[k];
            end
            r1_side <= i_side;
            r2_max  <= w_max;
            r2_neg  <= r1_neg;
            r2_side <= r1_side;
            r3_pos  <= w_pos;
            r3_zero <= (r2_max == '0);
            r3_neg  <= r2_neg;
            r3_side <= r2_side;
            r4_zero <= r3_zero;
            r4_neg  <= r3_neg;
            r4_side <= r3_side;
            r5_zero <= r4_zero;
            r5_neg  <= r4_neg;
            r5_side <= r4_side;
            r6_sum  <= SQ_W'(r5_sq[0]) + SQ_W'(r5_sq[1]) + SQ_W'(r5_sq[2]);
            r6_zero <= r5_zero;
            r6_neg  <= r5_neg;
            r6_side <= r5_side;
        end
    end

    // Square root of the sum gives the vector length.
    assign w_rt_in = {r6_side, r6_neg, r6_zero, r6_sm[0], r6_sm[1], r6_sm[2]};

    lav_isqrt #(
        .SW (RSW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_vld   (r6_vld),
        .i_rad   (r6_sum),
        .i_side  (w_rt_in),
        .o_vld   (w_rt_vld),
        .o_root  (w_len),
        .o_side  (w_rt_out)
    );

    assign {w_a_side, w_a_neg, w_a_zero, w_a_sm0, w_a_sm1, w_a_sm2} = w_rt_out;

    // Dividends scaled by 2^30 plus half the length for rounding.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_num[0] <= NUM_W'({w_a_sm0, {SCL_W{1'b0}}}) + NUM_W'(w_len >> 1);
            r7_num[1] <= NUM_W'({w_a_sm1, {SCL_W{1'b0}}}) + NUM_W'(w_len >> 1);
            r7_num[2] <= NUM_W'({w_a_sm2, {SCL_W{1'b0}}}) + NUM_W'(w_len >> 1);
            r7_den    <= w_len;
            r7_dside  <= {w_a_side, w_a_neg, w_a_zero};
        end
    end

    lav_div #(
        .SW (DSW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_vld   (r7_vld),
        .i_num   (r7_num),
        .i_den   (r7_den),
        .i_side  (r7_dside),
        .o_vld   (w_dv_vld),
        .o_quo   (w_quo),
        .o_side  (w_dv_side)
    );

    assign {w_b_side, w_b_neg, w_b_zero} = w_dv_side;

    // Restore the signs of the components.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_qx[k] = {1'b0, w_quo[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r8_vec[k] <= w_b_neg[k] ? -$signed(w_qx[k]) : $signed(w_qx[k]);
            end
            r8_ok   <= !w_b_zero;
            r8_side <= w_b_side;
        end
    end

    assign o_vld  = r8_vld;
    assign o_vec  = r8_vec;
    assign o_ok   = r8_ok;
    assign o_side = r8_side;

endmodule

// ===== rtl/lav_checker.sv =====
// Port-level checks of the look-at view matrix output sequence.
// Depends on lav_pkg; bound to look_at_view_matrix.
module lav_view_assert import lav_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic i_ready,
    input t_row i_row_index,
    input t_q   i_right_part,
    input t_q   i_up_part,
    input t_q   i_forward_part,
    input t_q   i_translation_part,
    input logic i_degenerate,
    input logic i_last_row
);
    // A row other than the last is followed at once by the next row of the item.
    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_ready && !i_last_row) |=>
            (i_valid && i_row_index == $past(i_row_index) + 1'b1))
        else $error("row sequence broken");

    // The last-row flag marks row two and only row two.
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_last_row == (i_row_index == ROW_LAST)))
        else $error("last_row does not match row_index");

    // A degenerate row carries zeros everywhere.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_degenerate) |->
            (i_right_part == '0 && i_up_part == '0 && i_forward_part == '0 &&
             i_translation_part == '0))
        else $error("degenerate row carries nonzero data");

    // Right and forward components never exceed one in magnitude.
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ($signed(i_right_part) <= Q30_ONE && $signed(i_right_part) >= -Q30_ONE &&
                     $signed(i_forward_part) <= Q30_ONE &&
                     $signed(i_forward_part) >= -Q30_ONE))
        else $error("unit vector component out of range");

    // A stalled transfer keeps its row.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_row_index)))
        else $error("stalled row changed");

endmodule

bind look_at_view_matrix lav_view_assert u_lav_view_assert (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (o_row.valid),
    .i_ready            (o_row.ready),
    .i_row_index        (o_row.row_index),
    .i_right_part       (o_row.right_part),
    .i_up_part          (o_row.up_part),
    .i_forward_part     (o_row.forward_part),
    .i_translation_part (o_row.translation_part),
    .i_degenerate       (o_row.degenerate),
    .i_last_row         (o_row.last_row)
);
